// File: hdl/djlt_pkg.sv
// ----------------------------------------------------------------------------
// djlt_pkg
// Shared types and codes for the directional junction lock table.
// ----------------------------------------------------------------------------
package djlt_pkg;

  // Stream widths (fixed by the transaction layout)
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // Operation codes carried in in_tuser[1:0]
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_RESERVE = 2'd0;
  localparam mode_t MODE_QUERY   = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;
  localparam mode_t MODE_UNREG   = 2'd3;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_SWEEP  = 4'b1000
  } state_t;

endpackage

// File: hdl/djlt_mem.sv
// ----------------------------------------------------------------------------
// djlt_mem
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module djlt_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 81,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/directional_junction_lock_table.sv
// ----------------------------------------------------------------------------
// directional_junction_lock_table
// Shared lock table indexed by resource; each entry holds a valid bit, the
// approach direction that holds it and an owner bitmap, kept in one RAM.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+-------------
//  in_     | in  | resource_id[8:0] approach_id[25:9]           | mode[1:0]
//          |     | owner_id[31:26]                             | owner_present[2]
//  out_    | out | granted[0], zero fill [7:1]                 | -
//
//  Reserve, query, release: RAM read, then modify/write back.
//  Unregister with a usable owner: one pipelined entry sweep through the RAM;
//  without one it takes the same read and modify/write back as the others.
//  After reset a clearing pass over all entries runs; in_tready stays low.
//  A new transaction is taken while a result waits in the output register; the
//  write-back step stalls only when that register is still full.
// ----------------------------------------------------------------------------
module directional_junction_lock_table
  import djlt_pkg::*;
#(
  parameter int RESOURCES      = 256,
  parameter int OWNERS         = 64,
  parameter int DIRECTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // resource_id[8:0], approach_id[25:9], owner_id[31:26]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[1:0], owner_present[2]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // granted[0], zeros [7:1]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(RESOURCES);
  localparam int ENT_W = 1 + DIRECTION_BITS + OWNERS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RESOURCES - 1);

  // --------------------------------------------------------------------------
  // input decode
  // --------------------------------------------------------------------------
  logic [8:0]                rraw;
  logic [16:0]               araw;
  logic [5:0]                oid;
  mode_t                     in_mode;
  logic                      in_res_ok, in_dir_ok, in_own_ok;
  logic [IDX_W-1:0]          in_idx;
  logic [DIRECTION_BITS-1:0] in_dir;
  logic [OWNERS-1:0]         in_bit;
  logic                      accept;

  assign rraw      = in_tdata[8:0];
  assign araw      = in_tdata[25:9];
  assign oid       = in_tdata[31:26];
  assign in_mode   = in_tuser[1:0];
  assign in_res_ok = !rraw[8] && (32'(rraw[7:0]) < RESOURCES);
  assign in_dir_ok = !araw[16] && ((32'(araw[15:0]) >> DIRECTION_BITS) == 32'd0);
  assign in_own_ok = in_tuser[2] && (32'(oid) < OWNERS);
  assign in_idx    = in_res_ok ? IDX_W'(32'(rraw[7:0])) : '0;
  assign in_dir    = DIRECTION_BITS'(32'(araw[15:0]));
  assign in_bit    = OWNERS'(64'd1 << oid);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic                      out_grant_r, out_grant_nxt;

  mode_t                     mode_r;
  logic                      res_ok_r, dir_ok_r, own_ok_r;
  logic [IDX_W-1:0]          idx_r;
  logic [DIRECTION_BITS-1:0] dir_r;
  logic [OWNERS-1:0]         bit_r;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // table RAM
  // --------------------------------------------------------------------------
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  djlt_mem #(
    .DEPTH (RESOURCES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // entry fields: {valid, direction, owners}
  logic                      rd_valid;
  logic [DIRECTION_BITS-1:0] rd_dir;
  logic [OWNERS-1:0]         rd_own;

  assign rd_valid = mem_rdata[ENT_W-1];
  assign rd_dir   = mem_rdata[ENT_W-2 -: DIRECTION_BITS];
  assign rd_own   = mem_rdata[OWNERS-1:0];

  // --------------------------------------------------------------------------
  // modify step for a single-entry operation
  // --------------------------------------------------------------------------
  logic              all_ok;
  logic              rmw_we, rmw_grant;
  logic [ENT_W-1:0]  rmw_wdata;
  logic [OWNERS-1:0] own_drop;
  logic [ENT_W-1:0]  sweep_wdata;

  assign all_ok   = res_ok_r && dir_ok_r && own_ok_r;
  assign own_drop = rd_own & ~bit_r;

  always_comb begin
    rmw_we    = 1'b0;
    rmw_grant = 1'b1;
    rmw_wdata = mem_rdata;
    case (mode_r)
      MODE_RESERVE: begin
        if (all_ok) begin
          if (!rd_valid) begin
            rmw_we    = 1'b1;
            rmw_wdata = {1'b1, dir_r, bit_r};
          end else if (rd_dir != dir_r) begin
            rmw_grant = 1'b0;
          end else begin
            rmw_we    = 1'b1;
            rmw_wdata = {1'b1, rd_dir, rd_own | bit_r};
          end
        end
      end
      MODE_QUERY: begin
        rmw_grant = !all_ok || !rd_valid || (rd_dir == dir_r) ||
                    ((rd_own & bit_r) != '0);
      end
      MODE_RELEASE: begin
        if (res_ok_r && own_ok_r && rd_valid) begin
          rmw_we    = 1'b1;
          rmw_wdata = {(own_drop != '0), rd_dir, own_drop};
        end
      end
      default: begin
        // unregister without a usable owner: nothing to change
        rmw_we = 1'b0;
      end
    endcase
  end

  // sweep step: drop the owner from a held entry, free it once empty
  assign sweep_wdata = rd_valid ? {(own_drop != '0), rd_dir, own_drop} : mem_rdata;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    mem_re         = 1'b0;
    mem_raddr      = in_idx;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r;
    mem_wdata      = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_grant_nxt  = out_grant_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mem_re = 1'b1;
          if (in_mode == MODE_UNREG && in_own_ok) begin
            mem_raddr = '0;
            cnt_nxt   = '0;
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        mem_waddr = idx_r;
        mem_wdata = rmw_wdata;
        if (out_free) begin
          mem_we         = rmw_we;
          out_tvalid_nxt = 1'b1;
          out_grant_nxt  = rmw_grant;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // write entry cnt_r while reading entry cnt_r + 1
        mem_wdata = sweep_wdata;
        if (cnt_r != LAST_IDX) begin
          mem_we    = 1'b1;
          mem_re    = 1'b1;
          mem_raddr = cnt_r + IDX_W'(1);
          cnt_nxt   = cnt_r + IDX_W'(1);
        end else if (out_free) begin
          mem_we         = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_grant_nxt  = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload: result and captured transaction
  always_ff @(posedge clk) begin
    out_grant_r <= out_grant_nxt;
    if (accept) begin
      mode_r   <= in_mode;
      res_ok_r <= in_res_ok;
      dir_ok_r <= in_dir_ok;
      own_ok_r <= in_own_ok;
      idx_r    <= in_idx;
      dir_r    <= in_dir;
      bit_r    <= in_bit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_W - 1)'(0), out_grant_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an accepted transaction always moves on to an entry access or a sweep
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ACCESS || state_r == ST_SWEEP))
    else $error("accepted transaction did not start table access");

  // the RAM is never read and written at the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write collide on one table entry");

  // a new result only comes from an access or the end of a sweep
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |->
      ($past(state_r) == ST_ACCESS || $past(state_r) == ST_SWEEP))
    else $error("result raised without a transaction in flight");

  // a refused reserve is only possible against a held entry
  a_refuse_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACCESS && mode_r == MODE_RESERVE && !rmw_grant) |-> rd_valid)
    else $error("reserve refused on a free entry");

endmodule
